@@ hw/rtl/mseq_pkg.sv @@
// Shared types and constants for the MIDI event step sequencer.
// No dependencies; used by every module of the block.
package mseq_pkg;

	// Input command codes
	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_ADD    = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_RUN_ENABLE       = 2'd0;
	localparam logic [1:0] REG_SAMPLES_PER_TICK = 2'd1;
	localparam logic [1:0] REG_LOOP_LENGTH      = 2'd2;

	localparam int unsigned CFG_DATA_W = 16;

	// Reset values of the configuration registers
	localparam logic [11:0] SPT_RESET  = 12'd48;
	localparam logic [15:0] LOOP_RESET = 16'd384;

	// One stored note event, 48 bits
	typedef struct packed {
		logic [15:0] position;
		logic [7:0]  ev_type;
		logic [7:0]  byte_one;
		logic [7:0]  byte_two;
		logic [7:0]  byte_three;
	} event_t;

	// Configuration register set
	typedef struct packed {
		logic        run_enable;
		logic [11:0] samples_per_tick;
		logic [15:0] loop_length;
	} cfg_t;

endpackage

@@ hw/rtl/mseq_event_mem.sv @@
// Event store: single-port-write, single-port-read synchronous RAM.
// Read data is registered. Uses mseq_pkg::event_t.
module mseq_event_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  mseq_pkg::event_t      wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output mseq_pkg::event_t      rdata
);

	mseq_pkg::event_t mem [DEPTH];
	mseq_pkg::event_t rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; holds its value when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/mseq_ctrl.sv @@
// Sequencer control: command decode, fill count, sample/tick counters,
// store scan and output register. Depends on mseq_pkg, drives mseq_event_mem.
module mseq_ctrl #(
	parameter int unsigned MAX_EVENTS = 64,
	parameter int unsigned AW         = 6,
	parameter int unsigned CW         = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mseq_pkg::cfg_t        cfg,
	// request channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            command,
	input  mseq_pkg::event_t      in_evt,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output mseq_pkg::event_t      out_evt,
	output logic                  out_last,
	// event store
	output logic                  mem_we,
	output logic [AW-1:0]         mem_waddr,
	output mseq_pkg::event_t      mem_wdata,
	output logic                  mem_re,
	output logic [AW-1:0]         mem_raddr,
	input  mseq_pkg::event_t      mem_rdata
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_READ  = 2'd1;
	localparam logic [1:0] ST_CHECK = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_EVENTS);

	logic [1:0]       state_q;
	logic [CW-1:0]    count_q;
	logic [11:0]      sample_q;
	logic [15:0]      tick_q;
	logic [15:0]      scan_tick_q;
	logic [AW-1:0]    idx_q;
	logic             pend_valid_q;
	mseq_pkg::event_t pend_q;
	logic             out_valid_q;
	mseq_pkg::event_t out_evt_q;
	logic             out_last_q;

	logic             in_acc;
	logic             is_add;
	logic             is_clear;
	logic             is_sample;
	logic             room;
	logic             start_scan;
	logic [11:0]      spt_m1;
	logic [15:0]      len_m1;
	logic             can_load;
	logic             hit;
	logic             load_out;
	logic             load_last;

	// Request decode
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign is_add    = in_acc && (command == mseq_pkg::CMD_ADD);
	assign is_clear  = in_acc && (command == mseq_pkg::CMD_CLEAR);
	assign is_sample = in_acc && (command == mseq_pkg::CMD_SAMPLE) && cfg.run_enable;
	assign room      = (count_q < COUNT_MAX);
	assign start_scan = is_sample && (sample_q == 12'd0) && (count_q != '0);

	// Wrap points; a zero period acts like one
	assign spt_m1 = (cfg.samples_per_tick == 12'd0) ? 12'd0 : cfg.samples_per_tick - 12'd1;
	assign len_m1 = (cfg.loop_length == 16'd0) ? 16'd0 : cfg.loop_length - 16'd1;

	// Store access: adds write at the fill count, the scan reads one entry
	assign mem_we    = is_add && room;
	assign mem_waddr = AW'(count_q);
	assign mem_wdata = in_evt;
	assign mem_re    = (state_q == ST_READ);
	assign mem_raddr = idx_q;

	// Output register handoff
	assign can_load = !out_valid_q || !out_stall;
	assign hit      = (mem_rdata.position == scan_tick_q);

	always_comb begin
		load_out  = 1'b0;
		load_last = 1'b0;
		case (state_q)
			ST_CHECK: begin
				load_out = hit && pend_valid_q && can_load;
			end
			ST_FLUSH: begin
				load_out  = pend_valid_q && can_load;
				load_last = 1'b1;
			end
			default: begin
				load_out = 1'b0;
			end
		endcase
	end

	// Fill count and prescaler/tick counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			sample_q <= '0;
			tick_q   <= '0;
		end else begin
			if (is_clear) begin
				count_q <= '0;
			end else if (is_add && room) begin
				count_q <= count_q + CW'(1);
			end
			if (is_sample) begin
				if (sample_q < spt_m1) begin
					sample_q <= sample_q + 12'd1;
				end else begin
					sample_q <= '0;
					tick_q   <= (tick_q < len_m1) ? tick_q + 16'd1 : 16'd0;
				end
			end
		end
	end

	// Scan sequencer: newest entry first, one match held back so the final
	// match can be marked as last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start_scan) begin
						idx_q   <= AW'(count_q - CW'(1));
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (!(hit && pend_valid_q && !can_load)) begin
						if (hit) begin
							pend_valid_q <= 1'b1;
						end
						if (idx_q == '0) begin
							state_q <= ST_FLUSH;
						end else begin
							idx_q   <= idx_q - AW'(1);
							state_q <= ST_READ;
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (can_load) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Scan payload registers
	always_ff @(posedge clk) begin
		if (start_scan) begin
			scan_tick_q <= tick_q;
		end
		if (state_q == ST_CHECK && hit && !(pend_valid_q && !can_load)) begin
			pend_q <= mem_rdata;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_evt_q  <= pend_q;
			out_last_q <= load_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_evt   = out_evt_q;
	assign out_last  = out_last_q;

	// Fill count never passes the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_MAX)
		else $error("fill count above store depth");

	// No held-back match survives outside a scan
	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_valid_q)
		else $error("pending match left after scan");

	// An add on a full store leaves the count alone
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(is_add && !room) |=> (count_q == COUNT_MAX))
		else $error("add on full store changed count");

	// The store is never written during a scan
	a_no_write_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !mem_we)
		else $error("store write during scan");

endmodule

@@ hw/rtl/midi_event_step_sequencer.sv @@
// MIDI event step sequencer: holds up to MAX_EVENTS note events and fires the
// ones whose position equals the current tick. An add or clear request does not
// hold the request channel, nor does a sample request that does not land on a
// tick boundary or finds the store empty. A sample request at prescaler zero
// scans the store newest first through the event RAM, each entry read, then
// compared, since the RAM's read data is registered; it holds the request
// channel until the scan is through, and longer while the result channel stalls
// and a match waits for the output register. Results come out in store order
// from newest to oldest, the last one flagged.
// Depends on mseq_pkg, mseq_ctrl and mseq_event_mem.
module midi_event_step_sequencer #(
	parameter int unsigned MAX_EVENTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [15:0] event_position,
	input  logic [7:0]  event_type,
	input  logic [7:0]  event_byte_one,
	input  logic [7:0]  event_byte_two,
	input  logic [7:0]  event_byte_three,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] fired_position,
	output logic [7:0]  fired_type,
	output logic [7:0]  fired_byte_one,
	output logic [7:0]  fired_byte_two,
	output logic [7:0]  fired_byte_three,
	output logic        last_fired
);

	localparam int unsigned AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
	localparam int unsigned CW = $clog2(MAX_EVENTS + 1);

	mseq_pkg::cfg_t   cfg_q;
	mseq_pkg::event_t in_evt;
	mseq_pkg::event_t out_evt;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	mseq_pkg::event_t mem_wdata;
	logic             mem_re;
	logic [AW-1:0]    mem_raddr;
	mseq_pkg::event_t mem_rdata;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.run_enable       <= 1'b1;
			cfg_q.samples_per_tick <= mseq_pkg::SPT_RESET;
			cfg_q.loop_length      <= mseq_pkg::LOOP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mseq_pkg::REG_RUN_ENABLE: begin
					cfg_q.run_enable <= cfg_data[0];
				end
				mseq_pkg::REG_SAMPLES_PER_TICK: begin
					cfg_q.samples_per_tick <= cfg_data[11:0];
				end
				mseq_pkg::REG_LOOP_LENGTH: begin
					cfg_q.loop_length <= cfg_data;
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign in_evt.position   = event_position;
	assign in_evt.ev_type    = event_type;
	assign in_evt.byte_one   = event_byte_one;
	assign in_evt.byte_two   = event_byte_two;
	assign in_evt.byte_three = event_byte_three;

	mseq_ctrl #(
		.MAX_EVENTS (MAX_EVENTS),
		.AW         (AW),
		.CW         (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.in_evt    (in_evt),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_evt   (out_evt),
		.out_last  (last_fired),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	mseq_event_mem #(
		.DEPTH (MAX_EVENTS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign fired_position   = out_evt.position;
	assign fired_type       = out_evt.ev_type;
	assign fired_byte_one   = out_evt.byte_one;
	assign fired_byte_two   = out_evt.byte_two;
	assign fired_byte_three = out_evt.byte_three;

endmodule

@@ dv/midi_event_step_sequencer_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for midi_event_step_sequencer: directed table, then random phases,
// with a cycle-free mirror of the event store predicting every fired event.
// Depends on mseq_pkg and the midi_event_step_sequencer RTL.
module midi_event_step_sequencer_test;

	localparam int unsigned MAX_EVENTS = 64;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// worst-case store scan after the last fired event, plus margin
	localparam int SCAN_DRAIN = 2 * MAX_EVENTS + 16;

	typedef struct packed {
		logic [1:0]        cmd;
		mseq_pkg::event_t  ev;
	} request_t;

	typedef struct packed {
		mseq_pkg::event_t ev;
		logic             last;
	} fired_t;

	typedef enum logic {ROW_REQUEST, ROW_REGISTER} row_kind_t;

	// one directed step: a request (typed < 0: predicted, else typed result count)
	// or a register write
	typedef struct {
		row_kind_t   kind;
		request_t    req;
		int          typed;
		fired_t      want;
		logic [1:0]  reg_index;
		logic [15:0] reg_data;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  command = '0;
	logic [15:0] event_position = '0;
	logic [7:0]  event_type = '0;
	logic [7:0]  event_byte_one = '0;
	logic [7:0]  event_byte_two = '0;
	logic [7:0]  event_byte_three = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] fired_position;
	logic [7:0]  fired_type;
	logic [7:0]  fired_byte_one;
	logic [7:0]  fired_byte_two;
	logic [7:0]  fired_byte_three;
	logic        last_fired;

	// mirror of the sequencer state
	mseq_pkg::event_t mirror_store [MAX_EVENTS];
	int unsigned      mirror_count;
	int unsigned      mirror_samples;
	int unsigned      mirror_tick;
	logic             mirror_run;
	logic [11:0]      mirror_spt;
	logic [15:0]      mirror_loop;

	fired_t pending_fires[$];
	int     mismatches = 0;
	bit     send_calm = 1'b0;
	bit     recv_calm = 1'b0;

	midi_event_step_sequencer #(
		.MAX_EVENTS(MAX_EVENTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.event_position(event_position),
		.event_type(event_type),
		.event_byte_one(event_byte_one),
		.event_byte_two(event_byte_two),
		.event_byte_three(event_byte_three),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.fired_position(fired_position),
		.fired_type(fired_type),
		.fired_byte_one(fired_byte_one),
		.fired_byte_two(fired_byte_two),
		.fired_byte_three(fired_byte_three),
		.last_fired(last_fired)
	);

	always #5 clk = ~clk;

	// Apply one accepted request to the mirror; queue its fired events if keep is set
	task automatic predict_fires(input request_t r, input bit keep);
		fired_t      hits[$];
		fired_t      f;
		int unsigned period;
		int unsigned span;
		case (r.cmd)
			mseq_pkg::CMD_ADD: begin
				// dropped silently when the store is full
				if (mirror_count < MAX_EVENTS) begin
					mirror_store[mirror_count] = r.ev;
					mirror_count++;
				end
			end
			mseq_pkg::CMD_CLEAR: begin
				mirror_count = 0;
			end
			mseq_pkg::CMD_SAMPLE: begin
				if (mirror_run) begin
					// fire only at prescaler zero, newest first
					if (mirror_samples == 0) begin
						for (int i = int'(mirror_count) - 1; i >= 0; i--) begin
							if (mirror_store[i].position == mirror_tick[15:0]) begin
								f.ev = mirror_store[i];
								f.last = 1'b0;
								hits.push_back(f);
							end
						end
					end
					if (hits.size() > 0)
						hits[hits.size() - 1].last = 1'b1;
					// zero period or zero loop behave as one
					period = (mirror_spt == 0) ? 1 : mirror_spt;
					span = (mirror_loop == 0) ? 1 : mirror_loop;
					if (mirror_samples < period - 1) begin
						mirror_samples++;
					end else begin
						mirror_samples = 0;
						if (mirror_tick < span - 1)
							mirror_tick++;
						else
							mirror_tick = 0;
					end
				end
			end
			default: ;
		endcase
		if (keep)
			foreach (hits[i]) pending_fires.push_back(hits[i]);
	endtask

	function automatic int draw_gap(bit calm);
		return calm ? 0 : int'($urandom_range(0, 11));
	endfunction

	// Offer one request after a random gap and hold it until accepted
	task automatic send_request(input request_t r, input int typed, input fired_t want);
		int gap;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		command <= r.cmd;
		event_position <= r.ev.position;
		event_type <= r.ev.ev_type;
		event_byte_one <= r.ev.byte_one;
		event_byte_two <= r.ev.byte_two;
		event_byte_three <= r.ev.byte_three;
		do @(posedge clk); while (in_stall);
		if (typed < 0) begin
			predict_fires(r, 1'b1);
		end else begin
			predict_fires(r, 1'b0);
			if (typed > 0)
				pending_fires.push_back(want);
		end
	endtask

	// Drop valid and wait for all fired events; optionally let a trailing scan finish
	task automatic pause_sender(input bit scan_drain);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_fires.size() != 0) @(posedge clk);
		if (scan_drain)
			repeat (SCAN_DRAIN) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] index, input logic [15:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (index)
			mseq_pkg::REG_RUN_ENABLE:       mirror_run = data[0];
			mseq_pkg::REG_SAMPLES_PER_TICK: mirror_spt = data[11:0];
			mseq_pkg::REG_LOOP_LENGTH:      mirror_loop = data;
			default: ;
		endcase
	endtask

	function automatic row_t req_row(logic [1:0] cmd, logic [15:0] pos, logic [7:0] ty,
			logic [7:0] b1, logic [7:0] b2, logic [7:0] b3, int typed);
		row_t row;
		row.kind = ROW_REQUEST;
		row.req.cmd = cmd;
		row.req.ev.position = pos;
		row.req.ev.ev_type = ty;
		row.req.ev.byte_one = b1;
		row.req.ev.byte_two = b2;
		row.req.ev.byte_three = b3;
		row.typed = typed;
		row.want = '0;
		row.reg_index = '0;
		row.reg_data = '0;
		return row;
	endfunction

	// sample request expected to fire exactly the given event, flagged last
	function automatic row_t fire_row(logic [15:0] pos, logic [7:0] ty, logic [7:0] b1,
			logic [7:0] b2, logic [7:0] b3);
		row_t row;
		row = req_row(mseq_pkg::CMD_SAMPLE, pos, ty, b1, b2, b3, 1);
		row.want.ev = row.req.ev;
		row.want.last = 1'b1;
		return row;
	endfunction

	function automatic row_t reg_row(logic [1:0] index, logic [15:0] data);
		row_t row;
		row = req_row(mseq_pkg::CMD_SAMPLE, '0, '0, '0, '0, '0, 0);
		row.kind = ROW_REGISTER;
		row.reg_index = index;
		row.reg_data = data;
		return row;
	endfunction

	// Random request, mostly samples and adds landing inside the loop
	function automatic request_t pick_request(int unsigned span);
		request_t    r;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		r.ev.position = 16'($urandom_range(0, span - 1));
		r.ev.ev_type = 8'($urandom);
		r.ev.byte_one = 8'($urandom);
		r.ev.byte_two = 8'($urandom);
		r.ev.byte_three = 8'($urandom);
		if (roll < 55) begin
			r.cmd = mseq_pkg::CMD_SAMPLE;
		end else if (roll < 80) begin
			r.cmd = mseq_pkg::CMD_ADD;
		end else if (roll < 90) begin
			r.cmd = mseq_pkg::CMD_ADD;
			r.ev.position = 16'($urandom);
		end else if (roll < 95) begin
			r.cmd = mseq_pkg::CMD_CLEAR;
		end else begin
			r.cmd = CMD_UNUSED;
		end
		return r;
	endfunction

	// Result receiver: random stall before each fired event
	initial begin : result_sink
		int wait_cycles;
		@(posedge arst_n);
		forever begin
			wait_cycles = draw_gap(recv_calm);
			if (wait_cycles > 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (wait_cycles - 1) @(negedge clk);
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// Compare each fired event with the oldest prediction
	always @(posedge clk) begin : check_fires
		fired_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_fires.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected fired event: pos=%h type=%h bytes=%h %h %h last=%b",
						fired_position, fired_type, fired_byte_one, fired_byte_two,
						fired_byte_three, last_fired);
			end else begin
				want = pending_fires.pop_front();
				if (fired_position !== want.ev.position || fired_type !== want.ev.ev_type ||
						fired_byte_one !== want.ev.byte_one ||
						fired_byte_two !== want.ev.byte_two ||
						fired_byte_three !== want.ev.byte_three || last_fired !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("fired mismatch: want %h %h %h %h %h %b, got %h %h %h %h %h %b",
							want.ev.position, want.ev.ev_type, want.ev.byte_one,
							want.ev.byte_two, want.ev.byte_three, want.last,
							fired_position, fired_type, fired_byte_one, fired_byte_two,
							fired_byte_three, last_fired);
				end
			end
		end
	end

	initial begin : watchdog
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		row_t        rows[$];
		request_t    r;
		fired_t      none;
		logic        run;
		logic [11:0] spt;
		logic [15:0] len;
		logic [15:0] p0;
		int unsigned span;
		none = '0;
		mirror_count = 0;
		mirror_samples = 0;
		mirror_tick = 0;
		mirror_run = 1'b1;
		mirror_spt = mseq_pkg::SPT_RESET;
		mirror_loop = mseq_pkg::LOOP_RESET;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed steps; counters are tracked in the notes
		// empty store right after reset
		rows.push_back(req_row(mseq_pkg::CMD_SAMPLE, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 0));
		rows.push_back(reg_row(mseq_pkg::REG_SAMPLES_PER_TICK, 16'd1));
		rows.push_back(reg_row(mseq_pkg::REG_LOOP_LENGTH, 16'd10));
		// prescaler sits above the new period: wraps, tick moves to 1
		rows.push_back(req_row(mseq_pkg::CMD_SAMPLE, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 0));
		rows.push_back(req_row(mseq_pkg::CMD_ADD, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 0));
		rows.push_back(req_row(mseq_pkg::CMD_ADD, 16'h0001, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0));
		rows.push_back(fire_row(16'h0001, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		rows.push_back(req_row(mseq_pkg::CMD_ADD, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0));
		rows.push_back(req_row(mseq_pkg::CMD_ADD, 16'h0002, 8'h90, 8'h3C, 8'h64, 8'hA5, 0));
		rows.push_back(req_row(mseq_pkg::CMD_ADD, 16'h0002, 8'h80, 8'h3C, 8'h7F, 8'h5A, 0));
		// two events at tick 2, newest first
		rows.push_back(req_row(mseq_pkg::CMD_SAMPLE, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, -1));
		rows.push_back(req_row(CMD_UNUSED, 16'h0003, 8'h12, 8'h34, 8'h56, 8'h78, 0));
		rows.push_back(reg_row(mseq_pkg::REG_RUN_ENABLE, 16'd0));
		rows.push_back(req_row(mseq_pkg::CMD_SAMPLE, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 0));
		rows.push_back(reg_row(mseq_pkg::REG_RUN_ENABLE, 16'd1));
		rows.push_back(req_row(mseq_pkg::CMD_SAMPLE, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, -1));
		// zero loop length; tick 4 lies above it and returns to zero
		rows.push_back(reg_row(mseq_pkg::REG_LOOP_LENGTH, 16'd0));
		rows.push_back(req_row(mseq_pkg::CMD_SAMPLE, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 0));
		rows.push_back(fire_row(16'h0000, 8'h00, 8'h00, 8'h00, 8'h00));
		// zero samples per tick: every sample fires
		rows.push_back(reg_row(mseq_pkg::REG_SAMPLES_PER_TICK, 16'd0));
		rows.push_back(fire_row(16'h0000, 8'h00, 8'h00, 8'h00, 8'h00));
		rows.push_back(req_row(mseq_pkg::CMD_CLEAR, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 0));
		rows.push_back(req_row(mseq_pkg::CMD_SAMPLE, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 0));

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_REGISTER) begin
				pause_sender(1'b1);
				write_register(rows[i].reg_index, rows[i].reg_data);
			end else begin
				send_request(rows[i].req, rows[i].typed, rows[i].want);
			end
		end

		// Random phases, each under its own register setting
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 0) begin
				run = 1'b1;
				spt = 12'd4095;
				len = 16'd65535;
			end else if (ph == 3) begin
				run = 1'b1;
				spt = 12'd1;
				len = 16'd10;
			end else begin
				run = ($urandom_range(0, 7) != 0);
				spt = ($urandom_range(0, 5) == 0) ? 12'($urandom) : 12'($urandom_range(0, 3));
				case ($urandom_range(0, 9))
					0:       len = 16'd0;
					1:       len = 16'($urandom);
					default: len = 16'($urandom_range(10, 16));
				endcase
			end
			pause_sender(1'b1);
			write_register(mseq_pkg::REG_RUN_ENABLE, {15'd0, run});
			write_register(mseq_pkg::REG_SAMPLES_PER_TICK, {4'd0, spt});
			write_register(mseq_pkg::REG_LOOP_LENGTH, len);
			send_calm = ($urandom_range(0, 3) == 0);
			recv_calm = ($urandom_range(0, 3) == 0);
			span = (len == 0) ? 1 : len;

			if (ph == 3) begin
				// fill past capacity, half of the events on one tick
				r = '0;
				r.cmd = mseq_pkg::CMD_CLEAR;
				send_request(r, -1, none);
				p0 = 16'($urandom_range(0, 9));
				for (int k = 0; k < MAX_EVENTS + 2; k++) begin
					r.cmd = mseq_pkg::CMD_ADD;
					r.ev.position = $urandom_range(0, 1) ? p0 : 16'($urandom_range(0, 9));
					r.ev.ev_type = 8'($urandom);
					r.ev.byte_one = 8'($urandom);
					r.ev.byte_two = 8'($urandom);
					r.ev.byte_three = 8'($urandom);
					send_request(r, -1, none);
				end
				r.cmd = mseq_pkg::CMD_SAMPLE;
				for (int k = 0; k < 12; k++)
					send_request(r, -1, none);
				r.cmd = mseq_pkg::CMD_CLEAR;
				send_request(r, -1, none);
			end else begin
				for (int k = 0; k < 4; k++) begin
					// sender holds off until the result channel has drained
					if ((ph == 5 && k == 2) || $urandom_range(0, 19) == 0)
						pause_sender(1'b0);
					send_request(pick_request(span), -1, none);
				end
			end
		end

		pause_sender(1'b1);
		if (mismatches == 0 && pending_fires.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
